@@ rtl/mbp_pkg.sv @@
`timescale 1ns / 1ps

package mbp_pkg;

  // field widths of the stream interface
  localparam int unsigned ValueWidth = 64;
  localparam int unsigned LenWidth   = 7;
  localparam int unsigned CountWidth = 51;
  localparam int unsigned ByteBits   = 8;
  localparam int unsigned MaxLen     = 64;

  // pending bits plus one full field
  localparam int unsigned MergeWidth = ValueWidth + ByteBits - 1;

  // command queue depth
  localparam int unsigned QueueDepth = 2;

  localparam logic ActAppend = 1'b0;
  localparam logic ActFlush  = 1'b1;

  typedef enum logic {
    OP_APPEND = 1'b0,
    OP_FLUSH  = 1'b1
  } op_e;

  typedef struct packed {
    logic                  action;
    logic [ValueWidth-1:0] field_value;
    logic [LenWidth-1:0]   field_len;
  } in_item_t;

  typedef struct packed {
    logic [ValueWidth-1:0] out_word;
    logic [3:0]            byte_count;
    logic [CountWidth-1:0] total_bits;
    logic                  aligned;
  } out_item_t;

  // classified command handed from front to back
  typedef struct packed {
    op_e                   op;
    logic [ValueWidth-1:0] value;
    logic [LenWidth-1:0]   len;
  } cmd_t;

endpackage

@@ rtl/mbp_front.sv @@
`timescale 1ns / 1ps

module mbp_front (
  input  mbp_pkg::in_item_t item_i,
  output mbp_pkg::cmd_t     cmd_o
);

  logic [mbp_pkg::LenWidth-1:0]   len_sat;
  logic [mbp_pkg::ValueWidth-1:0] val_mask;

  // clamp the length to one full field
  always_comb begin
    if (item_i.field_len > mbp_pkg::LenWidth'(mbp_pkg::MaxLen)) begin
      len_sat = mbp_pkg::LenWidth'(mbp_pkg::MaxLen);
    end else begin
      len_sat = item_i.field_len;
    end
  end

  // keep only the bits below the length
  always_comb begin
    if (len_sat[mbp_pkg::LenWidth-1]) begin
      val_mask = '1;
    end else begin
      val_mask = (mbp_pkg::ValueWidth'(1) << len_sat[mbp_pkg::LenWidth-2:0])
                 - mbp_pkg::ValueWidth'(1);
    end
  end

  // classify the item
  always_comb begin
    if (item_i.action == mbp_pkg::ActFlush) begin
      cmd_o.op    = mbp_pkg::OP_FLUSH;
      cmd_o.value = '0;
      cmd_o.len   = '0;
    end else begin
      cmd_o.op    = mbp_pkg::OP_APPEND;
      cmd_o.value = item_i.field_value & val_mask;
      cmd_o.len   = len_sat;
    end
  end

endmodule

@@ rtl/mbp_queue.sv @@
`timescale 1ns / 1ps

module mbp_queue #(
  parameter int unsigned Depth = mbp_pkg::QueueDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mbp_pkg::cmd_t push_cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output mbp_pkg::cmd_t pop_cmd_o
);

  localparam int unsigned PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntWidth = $clog2(Depth + 1);

  mbp_pkg::cmd_t       mem_q [Depth];
  logic [PtrWidth-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrWidth-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;

  assign full_o    = (cnt_q == CntWidth'(Depth));
  assign empty_o   = (cnt_q == '0);
  assign pop_cmd_o = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_q + PtrWidth'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_q + PtrWidth'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntWidth'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntWidth'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

@@ rtl/mbp_back.sv @@
`timescale 1ns / 1ps

module mbp_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  mbp_pkg::cmd_t      cmd_i,
  output logic               cmd_pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output mbp_pkg::out_item_t out_item_o
);

  localparam int unsigned MW = mbp_pkg::MergeWidth;
  localparam int unsigned CW = mbp_pkg::CountWidth;

  logic [7:0]    pend_bits_q, pend_bits_d;
  logic [2:0]    pend_cnt_q, pend_cnt_d;
  logic [CW-1:0] bit_total_q, bit_total_d;
  logic          out_valid_q;
  mbp_pkg::out_item_t out_q, out_d;

  logic          fire;
  logic [6:0]    total;
  logic [2:0]    rem;
  logic [3:0]    nbytes;
  logic [7:0]    held;
  logic [MW-1:0] merged;
  logic [7:0]    rem_mask;
  logic [63:0]   word;

  // take a command when the output register is free or being drained
  assign fire        = cmd_valid_i && (!out_valid_q || out_ready_i);
  assign cmd_pop_o   = fire;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // merge held bits in front of the new field
  always_comb begin
    total    = 7'(pend_cnt_q) + cmd_i.len;
    rem      = total[2:0];
    held     = pend_bits_q >> (4'd8 - {1'b0, pend_cnt_q});
    merged   = (MW'(held) << cmd_i.len) | MW'(cmd_i.value);
    rem_mask = (8'd1 << rem) - 8'd1;
  end

  // next state and result
  always_comb begin
    unique case (cmd_i.op)
      mbp_pkg::OP_FLUSH: begin
        if (pend_cnt_q != '0) begin
          word   = 64'(pend_bits_q);
          nbytes = 4'd1;
        end else begin
          word   = '0;
          nbytes = 4'd0;
        end
        pend_bits_d = '0;
        pend_cnt_d  = '0;
      end
      default: begin
        word        = 64'(merged >> rem);
        nbytes      = total[6:3];
        pend_bits_d = (merged[7:0] & rem_mask) << (4'd8 - {1'b0, rem});
        pend_cnt_d  = rem;
      end
    endcase
    bit_total_d       = bit_total_q + CW'({nbytes, 3'b000});
    out_d.out_word    = word;
    out_d.byte_count  = nbytes;
    out_d.total_bits  = bit_total_d + CW'(pend_cnt_d);
    out_d.aligned     = (pend_cnt_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_bits_q <= '0;
      pend_cnt_q  <= '0;
      bit_total_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        pend_bits_q <= pend_bits_d;
        pend_cnt_q  <= pend_cnt_d;
        bit_total_q <= bit_total_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= out_d;
    end
  end

endmodule

@@ rtl/msb_first_bit_packer_unit.sv @@
`timescale 1ns / 1ps

// channel  | handshake               | payload
// ---------+-------------------------+-----------------------------------------
// input    | in_valid_i/in_ready_o   | in_item_i  (action, value, len)
// output   | out_valid_o/out_ready_i | out_item_o (word, count, total, aligned)
//
// one item per clock sustained while the output is not stalled; an accepted item passes
// through the queue and then the output register, from which its result is offered.
// the merge of held bits with the new field is combinational in the back end.
// reset clears held bits, bit total, queue and output valid.
// a stalled output fills the output register and the queue; input ready drops
// only when the queue is full, after three items at the default depth.

module msb_first_bit_packer_unit #(
  parameter int unsigned QueueDepth = mbp_pkg::QueueDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  mbp_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output mbp_pkg::out_item_t out_item_o
);

  mbp_pkg::cmd_t front_cmd;
  mbp_pkg::cmd_t head_cmd;
  logic          q_full;
  logic          q_empty;
  logic          q_pop;
  logic          q_push;

  assign in_ready_o = !q_full;
  assign q_push     = in_valid_i && !q_full;

  // classify incoming items
  mbp_front u_front (
    .item_i (in_item_i),
    .cmd_o  (front_cmd)
  );

  // decoupling queue
  mbp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (front_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .empty_o    (q_empty),
    .pop_cmd_o  (head_cmd)
  );

  // bit merge and output register
  mbp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!q_empty),
    .cmd_i       (head_cmd),
    .cmd_pop_o   (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

@@ tb/msb_first_bit_packer_unit_test.sv @@
`timescale 1ns / 1ps

module msb_first_bit_packer_unit_test;

  localparam int unsigned IdleLimit  = 2000;
  localparam int unsigned HoldCycles = 40;
  localparam int unsigned DrainWait  = 8;
  localparam int unsigned NumPhases  = 5;
  localparam int unsigned PhaseItems = 180;
  localparam int unsigned NumDir     = 18;

  // percent of cycles the sender idles / the receiver stalls, per phase
  localparam int unsigned SendIdle  [NumPhases] = '{0, 69, 0, 32, 0};
  localparam int unsigned RecvStall [NumPhases] = '{0, 0, 69, 32, 0};

  // one directed row: stimulus, whether the result is typed in, typed result
  typedef struct packed {
    mbp_pkg::in_item_t  stim;
    logic               known;
    mbp_pkg::out_item_t known_res;
  } dir_row_t;

  localparam dir_row_t DirRows [NumDir] = '{
    // flush right after reset
    {mbp_pkg::ActFlush,  64'h0,                   7'd0,   1'b1, 64'h0, 4'd0, 51'd0, 1'b1},
    // zero-length append with all value bits set
    {mbp_pkg::ActAppend, 64'hffff_ffff_ffff_ffff, 7'd0,   1'b1, 64'h0, 4'd0, 51'd0, 1'b1},
    // full 64-bit field
    {mbp_pkg::ActAppend, 64'hffff_ffff_ffff_ffff, 7'd64,  1'b1,
     64'hffff_ffff_ffff_ffff, 4'd8, 51'd64, 1'b1},
    // length above 64 saturates
    {mbp_pkg::ActAppend, 64'h0123_4567_89ab_cdef, 7'd127, 1'b1,
     64'h0123_4567_89ab_cdef, 4'd8, 51'd128, 1'b1},
    {mbp_pkg::ActAppend, 64'h0,                   7'd65,  1'b1,
     64'h0, 4'd8, 51'd192, 1'b1},
    // short field, junk above the length
    {mbp_pkg::ActAppend, 64'hffff_ffff_ffff_fffd, 7'd3,   1'b0, 120'd0},
    // flush ignores value and length
    {mbp_pkg::ActFlush,  64'hffff_ffff_ffff_ffff, 7'd64,  1'b0, 120'd0},
    // flush when already aligned
    {mbp_pkg::ActFlush,  64'h0,                   7'd0,   1'b1,
     64'h0, 4'd0, 51'd200, 1'b1},
    {mbp_pkg::ActAppend, 64'h0000_0000_0000_007f, 7'd7,   1'b0, 120'd0},
    {mbp_pkg::ActAppend, 64'hffff_ffff_ffff_ffff, 7'd64,  1'b0, 120'd0},
    // zero-length append while bits are held
    {mbp_pkg::ActAppend, 64'hffff_ffff_ffff_ffff, 7'd0,   1'b0, 120'd0},
    {mbp_pkg::ActAppend, 64'h0000_0000_0000_0001, 7'd1,   1'b0, 120'd0},
    {mbp_pkg::ActAppend, 64'h0000_0000_0000_0015, 7'd5,   1'b0, 120'd0},
    {mbp_pkg::ActAppend, 64'h8000_0000_0000_0001, 7'd64,  1'b0, 120'd0},
    {mbp_pkg::ActAppend, 64'h0,                   7'd127, 1'b0, 120'd0},
    {mbp_pkg::ActFlush,  64'h0,                   7'd127, 1'b0, 120'd0},
    {mbp_pkg::ActAppend, 64'h0000_0000_0000_00a5, 7'd8,   1'b0, 120'd0},
    {mbp_pkg::ActAppend, 64'h5555_5555_5555_5555, 7'd63,  1'b0, 120'd0}
  };

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  mbp_pkg::in_item_t  in_item_i;
  logic               out_valid_o;
  logic               out_ready_i;
  mbp_pkg::out_item_t out_item_o;

  // predictor state
  logic [7:0]                     held_bits     = '0;
  logic [2:0]                     held_cnt      = '0;
  logic [mbp_pkg::CountWidth-1:0] released_bits = '0;

  mbp_pkg::out_item_t packed_q [$];
  logic               dir_known = 1'b0;
  mbp_pkg::out_item_t dir_expect = '0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_off_req   = 1'b0;
  int unsigned stuck_cycles   = 0;
  int unsigned err_cnt        = 0;
  int unsigned n_items        = 0;
  int unsigned n_results      = 0;
  int unsigned n_flushes      = 0;
  int unsigned n_saturated    = 0;

  msb_first_bit_packer_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // expected bytes for one item, advancing the held bits and the bit total
  function automatic mbp_pkg::out_item_t pack_field(input mbp_pkg::in_item_t it);
    mbp_pkg::out_item_t res;
    logic [71:0] acc;
    int unsigned len;
    int unsigned tot;
    int unsigned rem;
    res = '0;
    if (it.action == mbp_pkg::ActFlush) begin
      if (held_cnt != 0) begin
        res.out_word   = {56'd0, held_bits};
        res.byte_count = 4'd1;
        held_bits      = '0;
        held_cnt       = '0;
      end
    end else begin
      len = (it.field_len > mbp_pkg::MaxLen) ? mbp_pkg::MaxLen : it.field_len;
      // held bits on top, new field below, all right-aligned
      acc = ((72'(held_bits) >> (mbp_pkg::ByteBits - held_cnt)) << len) |
            (72'(it.field_value) & ((72'd1 << len) - 72'd1));
      tot = held_cnt + len;
      rem = tot % mbp_pkg::ByteBits;
      res.out_word   = 64'(acc >> rem);
      res.byte_count = 4'(tot / mbp_pkg::ByteBits);
      held_bits = 8'((acc & ((72'd1 << rem) - 72'd1)) << (mbp_pkg::ByteBits - rem));
      held_cnt  = 3'(rem);
    end
    released_bits  = released_bits +
                     mbp_pkg::CountWidth'(res.byte_count * mbp_pkg::ByteBits);
    res.total_bits = released_bits + mbp_pkg::CountWidth'(held_cnt);
    res.aligned    = (held_cnt == 0);
    return res;
  endfunction

  // random item, mostly short appends with some long and oversized ones, and some flushes
  function automatic mbp_pkg::in_item_t rand_item();
    mbp_pkg::in_item_t it;
    int unsigned       pick;
    it.field_value = {$urandom, $urandom};
    pick = $urandom_range(99);
    if (pick < 5) begin
      it.field_value = '1;
    end else if (pick < 10) begin
      it.field_value = '0;
    end
    it.action = ($urandom_range(99) < 15) ? mbp_pkg::ActFlush : mbp_pkg::ActAppend;
    pick = $urandom_range(99);
    if (pick < 60) begin
      it.field_len = 7'($urandom_range(16));
    end else if (pick < 85) begin
      it.field_len = 7'($urandom_range(64, 17));
    end else if (pick < 92) begin
      it.field_len = 7'(mbp_pkg::MaxLen);
    end else begin
      it.field_len = 7'($urandom_range(127, 65));
    end
    return it;
  endfunction

  // offer one item from a falling edge; returns at the falling edge after it is taken
  task automatic send_item(input mbp_pkg::in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // stop offering and wait until every expected result has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (packed_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // receiver: random stalls, or one long hold-off on request
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles - 1) @(negedge clk_i);
        hold_off_req = 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // compare results against the oldest expectation, then record new items
  always @(posedge clk_i) begin
    mbp_pkg::out_item_t want;
    if (out_valid_o && out_ready_i) begin
      n_results++;
      if (packed_q.size() == 0) begin
        $error("result with no item outstanding: %h", out_item_o);
        err_cnt++;
      end else begin
        want = packed_q.pop_front();
        if (out_item_o.out_word !== want.out_word) begin
          $error("out_word: expected %h, got %h", want.out_word, out_item_o.out_word);
          err_cnt++;
        end
        if (out_item_o.byte_count !== want.byte_count) begin
          $error("byte_count: expected %0d, got %0d", want.byte_count,
                 out_item_o.byte_count);
          err_cnt++;
        end
        if (out_item_o.total_bits !== want.total_bits) begin
          $error("total_bits: expected %0d, got %0d", want.total_bits,
                 out_item_o.total_bits);
          err_cnt++;
        end
        if (out_item_o.aligned !== want.aligned) begin
          $error("aligned: expected %b, got %b", want.aligned, out_item_o.aligned);
          err_cnt++;
        end
      end
    end
    if (in_valid_i && in_ready_o) begin
      want = pack_field(in_item_i);
      if (dir_known) begin
        want = dir_expect;
      end
      packed_q.push_back(want);
      n_items++;
      if (in_item_i.action == mbp_pkg::ActFlush) begin
        n_flushes++;
      end else if (in_item_i.field_len > mbp_pkg::MaxLen) begin
        n_saturated++;
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
    if (stuck_cycles >= IdleLimit) begin
      $display("msb_first_bit_packer_unit_test: errors");
      $finish;
    end
  end

  // reset, directed table, random phases, verdict
  initial begin
    int unsigned row;
    int unsigned ph;
    int unsigned k;
    in_valid_i = 1'b0;
    in_item_i  = '0;
    rst_ni     = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (row = 0; row < NumDir; row++) begin
      dir_known  = DirRows[row].known;
      dir_expect = DirRows[row].known_res;
      send_item(DirRows[row].stim);
    end
    drain();
    dir_known = 1'b0;

    for (ph = 0; ph < NumPhases; ph++) begin
      send_idle_pct  = SendIdle[ph];
      recv_stall_pct = RecvStall[ph];
      // last phase: long receiver hold-off while items keep coming
      if (ph == NumPhases - 1) begin
        hold_off_req = 1'b1;
      end
      for (k = 0; k < PhaseItems; k++) begin
        send_item(rand_item());
      end
      drain();
    end

    repeat (DrainWait) @(posedge clk_i);
    $display("run covered %0d items (%0d flushes, %0d oversized lengths), %0d results",
             n_items, n_flushes, n_saturated, n_results);
    $display("directed table of %0d rows, then %0d idle/stall phases incl. a long hold-off",
             NumDir, NumPhases);
    if (err_cnt == 0) begin
      $display("msb_first_bit_packer_unit_test: clean");
    end else begin
      $display("msb_first_bit_packer_unit_test: errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/mbp_pkg.sv
rtl/mbp_front.sv
rtl/mbp_queue.sv
rtl/mbp_back.sv
rtl/msb_first_bit_packer_unit.sv
tb/msb_first_bit_packer_unit_test.sv
